/* rtl/core/assert_macros.svh */
// Assertion macros shared by the blend core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define EAPB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eapb assertion failed");
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define EAPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eapb assertion failed");
`else
`define EAPB_ASSERT_IMPL(lbl, ante, cons)
`define EAPB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/core/eapb_pkg.sv */
// Types, constants and the luma function of the edge-adaptive pixel blend.
`default_nettype none
package eapb_pkg;

  localparam int LUMA_WR = 77;
  localparam int LUMA_WG = 150;
  localparam int LUMA_WB = 29;

  localparam logic [7:0] RANGE_LOW_RST  = 8'd16;
  localparam logic [7:0] RANGE_HIGH_RST = 8'd127;

  // Configuration register indexes.
  localparam logic [7:0] REG_RANGE_LOW  = 8'd0;
  localparam logic [7:0] REG_RANGE_HIGH = 8'd1;

  // Positions of the five pixels in the luma vector.
  localparam int PIX_C = 0;
  localparam int PIX_L = 1;
  localparam int PIX_R = 2;
  localparam int PIX_B = 3;
  localparam int PIX_A = 4;

  localparam int NUM_W = 18;

  typedef struct packed {
    logic [7:0] low;
    logic [7:0] high;
  } cfg_t;

  typedef struct packed {
    logic [4:0][7:0] luma;
    logic [2:0][8:0] hsum;
    logic [2:0][8:0] vsum;
    logic [23:0]     center;
  } s1_t;

  typedef struct packed {
    logic            blend;
    logic [7:0]      dh;
    logic [7:0]      dv;
    logic [9:0]      den2;
    logic [2:0][8:0] hsum;
    logic [2:0][8:0] vsum;
    logic [23:0]     center;
  } s2_t;

  typedef struct packed {
    logic                  blend;
    logic [9:0]            den2;
    logic [2:0][NUM_W-1:0] num;
    logic [23:0]           center;
  } s3_t;

  typedef struct packed {
    logic                  blend;
    logic [9:0]            den2;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][7:0]       quo;
    logic [23:0]           center;
  } dv_t;

  function automatic logic [7:0] luma_of(input logic [23:0] px);
    logic [15:0] s;
    s = 16'(px[23:16]) * 16'(LUMA_WR) + 16'(px[15:8]) * 16'(LUMA_WG)
      + 16'(px[7:0]) * 16'(LUMA_WB);
    return s[15:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/core/edge_adaptive_pixel_blend.sv */
// Edge-adaptive pixel blend, top level.
// Throughput: one word per cycle while out_stall is low; the seven stages are luma,
// range test, numerators and four two-bit stages of the shared-nothing divider.
// Reset clears all stage valid bits and loads range_low 16, range_high 127.
`default_nettype none
`include "assert_macros.svh"
module edge_adaptive_pixel_blend
  import eapb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [23:0] in_center_pixel,
  input  wire logic [23:0] in_left_pixel,
  input  wire logic [23:0] in_right_pixel,
  input  wire logic [23:0] in_below_pixel,
  input  wire logic [23:0] in_above_pixel,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_pixel,
  output logic             out_was_blended,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  localparam int NSTG = 7;

  cfg_t            cfg_r, cfg_nxt;
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG:0]   stg_rdy;
  s1_t             s1;
  s3_t             s3;
  dv_t             dv_out;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  cfg_nxt.low  = cfg_data;
        REG_RANGE_HIGH: cfg_nxt.high = cfg_data;
        default:        cfg_nxt      = cfg_r;
      endcase
    end
  end

  // A stage takes a new word when it is empty or its own word moves on.
  always_comb begin
    stg_rdy[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      stg_rdy[i] = !vld_r[i] || stg_rdy[i+1];
    end
    vld_nxt = vld_r;
    if (stg_rdy[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int i = 1; i < NSTG; i++) begin
      if (stg_rdy[i]) begin
        vld_nxt[i] = vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low  <= RANGE_LOW_RST;
      cfg_r.high <= RANGE_HIGH_RST;
      vld_r      <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign in_stall = !stg_rdy[0];

  eapb_luma u_luma (
    .clk          (clk),
    .en           (stg_rdy[0]),
    .center_pixel (in_center_pixel),
    .left_pixel   (in_left_pixel),
    .right_pixel  (in_right_pixel),
    .below_pixel  (in_below_pixel),
    .above_pixel  (in_above_pixel),
    .s1_r         (s1)
  );

  eapb_edge u_edge (
    .clk  (clk),
    .en   (stg_rdy[2:1]),
    .cfg  (cfg_r),
    .s1   (s1),
    .s3_r (s3)
  );

  eapb_div u_div (
    .clk    (clk),
    .en     (stg_rdy[6:3]),
    .s3     (s3),
    .dv_out (dv_out)
  );

  assign out_valid       = vld_r[NSTG-1];
  assign out_was_blended = dv_out.blend;
  assign out_pixel       = dv_out.blend ? {dv_out.quo[2], dv_out.quo[1], dv_out.quo[0]}
                                        : dv_out.center;

  `EAPB_ASSERT_NEXT(a_in_lands, in_valid && !in_stall, vld_r[0])
  `EAPB_ASSERT_IMPL(a_stall_full, in_stall, vld_r == {NSTG{1'b1}})
  `EAPB_ASSERT_IMPL(a_blend_den, vld_r[2] && s3.blend, s3.den2 != 10'd0)

endmodule
`default_nettype wire

/* rtl/core/eapb_luma.sv */
// First stage: luma of the five pixels and the per-channel pair sums.
`default_nettype none
module eapb_luma
  import eapb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [23:0] center_pixel,
  input  wire logic [23:0] left_pixel,
  input  wire logic [23:0] right_pixel,
  input  wire logic [23:0] below_pixel,
  input  wire logic [23:0] above_pixel,
  output s1_t              s1_r
);

  s1_t s1_nxt;

  always_comb begin
    s1_nxt.luma[PIX_C] = luma_of(center_pixel);
    s1_nxt.luma[PIX_L] = luma_of(left_pixel);
    s1_nxt.luma[PIX_R] = luma_of(right_pixel);
    s1_nxt.luma[PIX_B] = luma_of(below_pixel);
    s1_nxt.luma[PIX_A] = luma_of(above_pixel);
    for (int c = 0; c < 3; c++) begin
      s1_nxt.hsum[c] = 9'(left_pixel[8*c +: 8]) + 9'(right_pixel[8*c +: 8]);
      s1_nxt.vsum[c] = 9'(below_pixel[8*c +: 8]) + 9'(above_pixel[8*c +: 8]);
    end
    s1_nxt.center = center_pixel;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/eapb_edge.sv */
// Second and third stages: range test, edge gradients and blend numerators.
`default_nettype none
module eapb_edge
  import eapb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [1:0] en,
  input  wire cfg_t       cfg,
  input  wire s1_t        s1,
  output s3_t             s3_r
);

  s2_t s2_r, s2_nxt;
  s3_t s3_nxt;

  always_comb begin
    logic [7:0] lmin;
    logic [7:0] lmax;
    logic [7:0] range;
    lmin = s1.luma[0];
    lmax = s1.luma[0];
    for (int i = 1; i < 5; i++) begin
      if (s1.luma[i] < lmin) lmin = s1.luma[i];
      if (s1.luma[i] > lmax) lmax = s1.luma[i];
    end
    range = lmax - lmin;
    s2_nxt.dh = (s1.luma[PIX_L] > s1.luma[PIX_R]) ? s1.luma[PIX_L] - s1.luma[PIX_R]
                                                   : s1.luma[PIX_R] - s1.luma[PIX_L];
    s2_nxt.dv = (s1.luma[PIX_B] > s1.luma[PIX_A]) ? s1.luma[PIX_B] - s1.luma[PIX_A]
                                                   : s1.luma[PIX_A] - s1.luma[PIX_B];
    s2_nxt.den2  = {9'(s2_nxt.dh) + 9'(s2_nxt.dv), 1'b0};
    // A flat neighbourhood has no gradient to weight by, so the centre passes.
    s2_nxt.blend = (range >= cfg.low) && (range <= cfg.high) && (s2_nxt.den2 != '0);
    s2_nxt.hsum   = s1.hsum;
    s2_nxt.vsum   = s1.vsum;
    s2_nxt.center = s1.center;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s3_nxt.num[c] = NUM_W'(s2_r.hsum[c]) * NUM_W'(s2_r.dv)
                    + NUM_W'(s2_r.vsum[c]) * NUM_W'(s2_r.dh);
    end
    s3_nxt.blend  = s2_r.blend;
    s3_nxt.den2   = s2_r.den2;
    s3_nxt.center = s2_r.center;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s2_r <= s2_nxt;
    end
    if (en[1]) begin
      s3_r <= s3_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/eapb_div.sv */
// Pipelined restoring divider: two quotient bits per stage over four stages.
`default_nettype none
module eapb_div
  import eapb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic [3:0] en,
  input  wire s3_t        s3,
  output dv_t             dv_out
);

  dv_t src    [4];
  dv_t st_r   [4];
  dv_t st_nxt [4];

  always_comb begin
    src[0].blend  = s3.blend;
    src[0].den2   = s3.den2;
    src[0].rem    = s3.num;
    src[0].quo    = '0;
    src[0].center = s3.center;
    for (int j = 1; j < 4; j++) begin
      src[j] = st_r[j-1];
    end
  end

  // The numerator is below 256 times the divisor, so eight quotient bits suffice
  // and the remainder never exceeds the numerator width.
  for (genvar j = 0; j < 4; j++) begin : g_stage
    always_comb begin
      logic [NUM_W-1:0] trial;
      st_nxt[j] = src[j];
      for (int c = 0; c < 3; c++) begin
        for (int b = 0; b < 2; b++) begin
          trial = NUM_W'(src[j].den2) << (7 - 2*j - b);
          if (st_nxt[j].rem[c] >= trial) begin
            st_nxt[j].rem[c] = st_nxt[j].rem[c] - trial;
            st_nxt[j].quo[c][7 - 2*j - b] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st_r[j] <= st_nxt[j];
      end
    end
  end

  assign dv_out = st_r[3];

endmodule
`default_nettype wire
